>>> sv/ceps_pkg.sv
package ceps_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int DEFAULT_TIME_BITS   = 24;

   localparam int EVENT_TIME_BITS = 24;
   localparam int MSG_BITS        = 26;
   localparam int MAX_LENGTH      = 3;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_TICK   = 2'd1,
      OP_REWIND = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TICK_DIVIDE = 2'd0,
      CSR_ONE_SHOT    = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [MSG_BITS-1:0] msg;
      logic                wrapped;
      logic                halted;
   } emit_type;

endpackage

>>> sv/ceps_table.sv
module ceps_table #(
   parameter  int TABLE_DEPTH = ceps_pkg::DEFAULT_TABLE_DEPTH,
   parameter  int TIME_BITS   = ceps_pkg::DEFAULT_TIME_BITS,
   localparam int AddrBits    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int EntryBits   = TIME_BITS + ceps_pkg::MSG_BITS
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrBits-1:0]  wr_addr,
   input  logic [EntryBits-1:0] wr_data,
   input  logic [AddrBits-1:0]  rd_addr,
   output logic [EntryBits-1:0] rd_data
);
   import ceps_pkg::*;

   logic [EntryBits-1:0] mem [TABLE_DEPTH];
   logic [EntryBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/clip_event_playback_sequencer.sv
// Append, rewind, clear and ticks that do not scan complete in idle; busy stays low.
// A scanning tick makes one compare per cycle on a registered table read issued in the
// cycle before, then one closing step (the missing compare, or the
// flush when one-shot play halts). Busy stays high from accept through the closing step.
// Each message appears on rsp_valid for one cycle; the receiver cannot stall.
// Synchronous active-high reset empties the table, rewinds play, tick_divide 1, one_shot 0.
module clip_event_playback_sequencer #(
   parameter int TABLE_DEPTH = ceps_pkg::DEFAULT_TABLE_DEPTH,
   parameter int TIME_BITS   = ceps_pkg::DEFAULT_TIME_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  ceps_pkg::opcode_type                  req_opcode,
   input  logic [ceps_pkg::EVENT_TIME_BITS-1:0]  req_event_time,
   input  logic [7:0]                            req_in_byte0,
   input  logic [7:0]                            req_in_byte1,
   input  logic [7:0]                            req_in_byte2,
   input  logic [2:0]                            req_in_length,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_out_byte0,
   output logic [7:0]                            rsp_out_byte1,
   output logic [7:0]                            rsp_out_byte2,
   output logic [1:0]                            rsp_out_length,
   output logic                                  rsp_wrapped,
   output logic                                  rsp_halted,
   output logic                                  rsp_last_of_tick,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ceps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ceps_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import ceps_pkg::*;

   localparam int AddrBits  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CountBits = $clog2(TABLE_DEPTH + 1);
   localparam int EntryBits = TIME_BITS + MSG_BITS;
   localparam logic [CountBits-1:0] DepthCount = CountBits'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH
   } state_type;

   state_type              state_ff, state_in;
   logic [CountBits-1:0]   count_ff, count_in;
   logic [AddrBits-1:0]    pos_ff, pos_in;
   logic [15:0]            presc_ff, presc_in;
   logic [TIME_BITS-1:0]   clip_ff, clip_in;
   logic                   playing_ff, playing_in;
   logic [CountBits-1:0]   fired_ff, fired_in;
   logic [15:0]            divide_ff, divide_in;
   logic                   one_shot_ff, one_shot_in;
   logic                   pend_valid_ff, pend_valid_in;
   emit_type               pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   emit_type               rsp_ff, rsp_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   wr_en;
   logic [EntryBits-1:0]   wr_data;
   logic [EntryBits-1:0]   rd_data;
   logic [TIME_BITS-1:0]   rd_time;
   logic [MSG_BITS-1:0]    rd_msg;
   logic [TIME_BITS-1:0]   ev_time;
   logic [MSG_BITS-1:0]    ev_msg;
   logic [15:0]            divide_eff;
   logic [16:0]            step_sum;
   logic                   step_roll;
   logic [15:0]            step_presc;
   logic [TIME_BITS-1:0]   step_clip;
   logic [CountBits-1:0]   pos_next;
   logic                   hit;

   ceps_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrBits-1:0]),
      .wr_data (wr_data),
      .rd_addr (pos_in),
      .rd_data (rd_data)
   );

   assign rd_time = rd_data[EntryBits-1:MSG_BITS];
   assign rd_msg  = rd_data[MSG_BITS-1:0];

   // zero bytes at or past the message length
   always_comb begin
      ev_time = TIME_BITS'(req_event_time);
      ev_msg  = {req_in_length[1:0],
                 (req_in_length >= 3'd3) ? req_in_byte2 : 8'h00,
                 (req_in_length >= 3'd2) ? req_in_byte1 : 8'h00,
                 (req_in_length >= 3'd1) ? req_in_byte0 : 8'h00};
      wr_data = {ev_time, ev_msg};
   end

   // prescaler advance from the current state
   always_comb begin
      divide_eff = (divide_ff == 16'd0) ? 16'd1 : divide_ff;
      step_sum   = {1'b0, presc_ff} + 17'd1;
      step_roll  = step_sum >= {1'b0, divide_eff};
      step_presc = step_roll ? 16'd0 : step_sum[15:0];
      step_clip  = step_roll ? clip_ff + TIME_BITS'(1) : clip_ff;
   end

   always_comb begin
      pos_next = CountBits'(pos_ff) + CountBits'(1);
      hit      = (fired_ff < count_ff) && (rd_time == clip_ff);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      presc_in      = presc_ff;
      clip_in       = clip_ff;
      playing_in    = playing_ff;
      fired_in      = fired_ff;
      divide_in     = divide_ff;
      one_shot_in   = one_shot_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TICK_DIVIDE: divide_in   = csr_wdata;
            CSR_ONE_SHOT:    one_shot_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_opcode) inside
                  OP_APPEND: begin
                     if (req_in_length <= 3'(MAX_LENGTH) && count_ff < DepthCount) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CountBits'(1);
                     end
                  end
                  OP_TICK: begin
                     if (playing_ff) begin
                        if (presc_ff == 16'd0 && count_ff != '0) begin
                           state_in      = S_SCAN;
                           fired_in      = '0;
                           pend_valid_in = 1'b0;
                        end else begin
                           presc_in = step_presc;
                           clip_in  = step_clip;
                        end
                     end
                  end
                  OP_REWIND, OP_CLEAR: begin
                     pos_in     = '0;
                     presc_in   = 16'd0;
                     clip_in    = '0;
                     playing_in = 1'b1;
                     if (req_opcode == OP_CLEAR) begin
                        count_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               // release the previous match; the new one waits to learn if it is last
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in   = 1'b1;
               pend_in.msg     = rd_msg;
               pend_in.wrapped = 1'b0;
               pend_in.halted  = 1'b0;
               fired_in        = fired_ff + CountBits'(1);
               if (pos_next >= count_ff) begin
                  pos_in = '0;
                  if (one_shot_ff) begin
                     playing_in     = 1'b0;
                     pend_in.halted = 1'b1;
                     state_in       = S_FLUSH;
                  end else begin
                     clip_in         = '0;
                     presc_in        = 16'd0;
                     pend_in.wrapped = 1'b1;
                  end
               end else begin
                  pos_in = pos_next[AddrBits-1:0];
               end
            end else begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
                  rsp_last_in  = 1'b1;
               end
               pend_valid_in = 1'b0;
               presc_in      = step_presc;
               clip_in       = step_clip;
               state_in      = S_IDLE;
            end
         end
         S_FLUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_in        = pend_ff;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pos_ff        <= '0;
         presc_ff      <= 16'd0;
         clip_ff       <= '0;
         playing_ff    <= 1'b1;
         fired_ff      <= '0;
         divide_ff     <= 16'd1;
         one_shot_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         presc_ff      <= presc_in;
         clip_ff       <= clip_in;
         playing_ff    <= playing_in;
         fired_ff      <= fired_in;
         divide_ff     <= divide_in;
         one_shot_ff   <= one_shot_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte0    = rsp_ff.msg[7:0];
   assign rsp_out_byte1    = rsp_ff.msg[15:8];
   assign rsp_out_byte2    = rsp_ff.msg[23:16];
   assign rsp_out_length   = rsp_ff.msg[25:24];
   assign rsp_wrapped      = rsp_ff.wrapped;
   assign rsp_halted       = rsp_ff.halted;
   assign rsp_last_of_tick = rsp_last_ff;

   a_halt_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |-> rsp_last_of_tick)
      else $error("halting beat not marked last of tick");

   a_wrap_halt_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_wrapped && rsp_halted))
      else $error("beat both wrapped and halted");

   a_no_rsp_after_cmd: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode != OP_TICK |=> !rsp_valid)
      else $error("beat produced by a non-tick command");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCount)
      else $error("entry count beyond table depth");

   a_halt_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |-> !playing_ff)
      else $error("play still running after halt");

endmodule

>>> test/tb_clip_event_playback_sequencer.sv
`timescale 1ns / 1ps

module tb_clip_event_playback_sequencer;
   import ceps_pkg::*;

   localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
   localparam int STALL_LIMIT = 1000;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] length;
      logic       wrapped;
      logic       halted;
      logic       last;
   } note_type;

   typedef struct packed {
      logic          is_reg;
      csr_index_type reg_idx;
      logic [15:0]   reg_val;
      opcode_type    op;
      logic [23:0]   stamp;
      logic [7:0]    b0;
      logic [7:0]    b1;
      logic [7:0]    b2;
      logic [2:0]    len;
      logic          typed;
      logic [1:0]    n_typed;
      note_type      e0;
      note_type      e1;
   } step_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   opcode_type                req_opcode = OP_TICK;
   logic [EVENT_TIME_BITS-1:0] req_event_time = '0;
   logic [7:0]                req_in_byte0 = '0;
   logic [7:0]                req_in_byte1 = '0;
   logic [7:0]                req_in_byte2 = '0;
   logic [2:0]                req_in_length = '0;
   logic                      rsp_valid;
   logic [7:0]                rsp_out_byte0;
   logic [7:0]                rsp_out_byte1;
   logic [7:0]                rsp_out_byte2;
   logic [1:0]                rsp_out_length;
   logic                      rsp_wrapped;
   logic                      rsp_halted;
   logic                      rsp_last_of_tick;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   clip_event_playback_sequencer dut (.*);

   always #1 clock = ~clock;

   // sequencer image
   logic [23:0] slot_time [DEPTH];
   note_type    slot_note [DEPTH];
   int          stored = 0;
   int          play_pos = 0;
   int          prescale = 0;
   logic [23:0] clip_now = '0;
   bit          running = 1'b1;
   logic [15:0] divide_reg = 16'd1;
   bit          one_shot_reg = 1'b0;

   note_type fresh[$];
   note_type due_messages[$];
   step_type script[$];
   int       errors = 0;
   int       beats_sent = 0;
   int       quiet_cycles = 0;
   bit       no_idle = 1'b0;

   function automatic void add_fresh(note_type n);
      fresh.insert(fresh.size(), n);
   endfunction

   function automatic void add_due(note_type n);
      due_messages.insert(due_messages.size(), n);
   endfunction

   function automatic void add_row(step_type s);
      script.insert(script.size(), s);
   endfunction

   function automatic void predict_messages(opcode_type op, logic [23:0] stamp,
                                            logic [7:0] b0, logic [7:0] b1,
                                            logic [7:0] b2, logic [2:0] len);
      note_type n;
      int       fired;
      fresh.delete();
      case (op) inside
         OP_APPEND: begin
            if (len <= MAX_LENGTH && stored < DEPTH) begin
               n = '0;
               n.byte0 = (len >= 1) ? b0 : 8'h00;
               n.byte1 = (len >= 2) ? b1 : 8'h00;
               n.byte2 = (len >= 3) ? b2 : 8'h00;
               n.length = len[1:0];
               slot_time[stored] = stamp;
               slot_note[stored] = n;
               stored++;
            end
         end
         OP_TICK: begin
            if (running) begin
               if (prescale == 0) begin
                  fired = 0;
                  while (running && fired < stored && play_pos < stored &&
                         slot_time[play_pos] == clip_now) begin
                     n = slot_note[play_pos];
                     fired++;
                     play_pos++;
                     if (play_pos >= stored) begin
                        play_pos = 0;
                        if (one_shot_reg) begin
                           running = 1'b0;
                           n.halted = 1'b1;
                        end else begin
                           // loop restart: time-zero entries fire in this same tick
                           clip_now = '0;
                           prescale = 0;
                           n.wrapped = 1'b1;
                        end
                     end
                     add_fresh(n);
                  end
                  if (fresh.size() > 0) begin
                     n = fresh.pop_back();
                     n.last = 1'b1;
                     add_fresh(n);
                  end
               end
               if (running) begin
                  prescale++;
                  if (prescale >= ((divide_reg == 0) ? 1 : divide_reg)) begin
                     prescale = 0;
                     clip_now++;
                  end
               end
            end
         end
         OP_REWIND, OP_CLEAR: begin
            if (op == OP_CLEAR) stored = 0;
            play_pos = 0;
            prescale = 0;
            clip_now = '0;
            running = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_messages
      note_type want;
      if (!reset && rsp_valid) begin
         if (due_messages.size() == 0) begin
            $display("%0t: unexpected message, expected none, actual %h %h %h len %0d",
                     $time, rsp_out_byte0, rsp_out_byte1, rsp_out_byte2, rsp_out_length);
            errors++;
         end else begin
            want = due_messages.pop_front();
            check_field("out_byte0", want.byte0, rsp_out_byte0);
            check_field("out_byte1", want.byte1, rsp_out_byte1);
            check_field("out_byte2", want.byte2, rsp_out_byte2);
            check_field("out_length", want.length, rsp_out_length);
            check_field("wrapped", want.wrapped, rsp_wrapped);
            check_field("halted", want.halted, rsp_halted);
            check_field("last_of_tick", want.last, rsp_last_of_tick);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("clip_event_playback_sequencer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic send(opcode_type op, logic [23:0] stamp, logic [7:0] b0, logic [7:0] b1,
                       logic [7:0] b2, logic [2:0] len, bit keep);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_event_time <= stamp;
      req_in_byte0 <= b0;
      req_in_byte1 <= b1;
      req_in_byte2 <= b2;
      req_in_length <= len;
      do @(posedge clock); while (busy);
      beats_sent++;
      predict_messages(op, stamp, b0, b1, b2, len);
      if (keep) begin
         foreach (fresh[i]) add_due(fresh[i]);
      end
   endtask

   // hold the sender until every message is out and the block has settled
   task automatic wait_drained();
      start <= 1'b0;
      while (due_messages.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TICK_DIVIDE) divide_reg = val;
      else one_shot_reg = val[0];
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 1))
         send(OP_APPEND, 24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              3'($urandom_range(4, 7)), 1'b1);
      else
         send(OP_APPEND, 24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              3'($urandom_range(0, 3)), 1'b1);
   endtask

   task automatic play_phase(logic [15:0] div, bit stop_at_end, int quota, bit steady);
      int          goal;
      int          ticks;
      int          r;
      logic [23:0] stamp;
      write_reg(CSR_TICK_DIVIDE, div);
      write_reg(CSR_ONE_SHOT, {15'd0, stop_at_end});
      no_idle = steady;
      goal = beats_sent + quota;
      while (beats_sent < goal) begin
         if ($urandom_range(0, 3) == 0) send(OP_REWIND, 24'($urandom), 0, 0, 0, 0, 1'b1);
         else send(OP_CLEAR, 24'($urandom), 0, 0, 0, 0, 1'b1);
         stamp = 24'($urandom_range(0, 2));
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            send(OP_APPEND, stamp, 8'($urandom), 8'($urandom), 8'($urandom),
                 3'($urandom_range(0, MAX_LENGTH)), 1'b1);
            stamp = stamp + 24'($urandom_range(0, 2));
         end
         // enough ticks to run the clip to its end, capped for slow dividers
         ticks = (stamp + 2) * div + $urandom_range(0, 6);
         if (ticks > 32) ticks = 32;
         repeat (ticks) begin
            r = $urandom_range(0, 39);
            if (r == 0) send(OP_REWIND, 0, 0, 0, 0, 0, 1'b1);
            else if (r == 1) wait_drained();
            else if (r == 2) send_noise();
            send(OP_TICK, 24'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 3'($urandom), 1'b1);
         end
      end
   endtask

   function automatic note_type note(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                     logic [1:0] len, logic w, logic h, logic l);
      note_type n;
      n.byte0 = b0;
      n.byte1 = b1;
      n.byte2 = b2;
      n.length = len;
      n.wrapped = w;
      n.halted = h;
      n.last = l;
      return n;
   endfunction

   function automatic step_type op_row(opcode_type op, logic [23:0] stamp = 0,
                                       logic [7:0] b0 = 0, logic [7:0] b1 = 0,
                                       logic [7:0] b2 = 0, logic [2:0] len = 0,
                                       int n_typed = -1,
                                       note_type e0 = '0, note_type e1 = '0);
      step_type s;
      s = '0;
      s.op = op;
      s.stamp = stamp;
      s.b0 = b0;
      s.b1 = b1;
      s.b2 = b2;
      s.len = len;
      s.typed = (n_typed >= 0);
      s.n_typed = (n_typed >= 0) ? n_typed[1:0] : 2'd0;
      s.e0 = e0;
      s.e1 = e1;
      return s;
   endfunction

   function automatic step_type reg_row(csr_index_type idx, logic [15:0] val);
      step_type s;
      s = '0;
      s.is_reg = 1'b1;
      s.reg_idx = idx;
      s.reg_val = val;
      s.op = OP_TICK;
      return s;
   endfunction

   initial begin
      // tick on an empty table, then a small clip with every length
      add_row(op_row(OP_TICK, 0, 0, 0, 0, 0, 0));
      add_row(op_row(OP_CLEAR));
      add_row(op_row(OP_APPEND, 24'd0, 8'hFF, 8'hFF, 8'hFF, 3'd3));
      add_row(op_row(OP_APPEND, 24'd0, 8'hAA, 8'h55, 8'h11, 3'd0));
      add_row(op_row(OP_APPEND, 24'd1, 8'h5A, 8'h33, 8'hC3, 3'd1));
      add_row(op_row(OP_APPEND, 24'd2, 8'h12, 8'h34, 8'h56, 3'd2));
      add_row(op_row(OP_APPEND, 24'd3, 8'h77, 8'h77, 8'h77, 3'd7, 0));
      add_row(op_row(OP_APPEND, 24'd3, 8'h77, 8'h77, 8'h77, 3'd4, 0));
      add_row(op_row(OP_TICK, 0, 0, 0, 0, 0, 2,
                     note(8'hFF, 8'hFF, 8'hFF, 2'd3, 0, 0, 0),
                     note(8'h00, 8'h00, 8'h00, 2'd0, 0, 0, 1)));
      add_row(op_row(OP_TICK, 0, 0, 0, 0, 0, 1,
                     note(8'h5A, 8'h00, 8'h00, 2'd1, 0, 0, 1)));
      add_row(op_row(OP_TICK));
      add_row(op_row(OP_TICK));
      add_row(reg_row(CSR_ONE_SHOT, 16'd1));
      add_row(op_row(OP_REWIND));
      add_row(op_row(OP_TICK));
      add_row(op_row(OP_TICK));
      add_row(op_row(OP_TICK, 0, 0, 0, 0, 0, 1,
                     note(8'h12, 8'h34, 8'h00, 2'd2, 0, 1, 1)));
      add_row(op_row(OP_TICK, 0, 0, 0, 0, 0, 0));
      add_row(reg_row(CSR_TICK_DIVIDE, 16'd3));
      add_row(op_row(OP_REWIND));
      add_row(op_row(OP_TICK));
      add_row(op_row(OP_TICK, 0, 0, 0, 0, 0, 0));
      add_row(op_row(OP_TICK));
      add_row(op_row(OP_TICK));
      add_row(op_row(OP_APPEND, 24'hFFFFFF, 8'h00, 8'h00, 8'h00, 3'd3));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_reg) begin
            write_reg(script[i].reg_idx, script[i].reg_val);
         end else begin
            send(script[i].op, script[i].stamp, script[i].b0, script[i].b1, script[i].b2,
                 script[i].len, !script[i].typed);
            if (script[i].typed && script[i].n_typed > 0) add_due(script[i].e0);
            if (script[i].typed && script[i].n_typed > 1) add_due(script[i].e1);
         end
      end

      play_phase(16'd1, 1'b0, 30, 1'b0);
      play_phase(16'd2, 1'b1, 24, 1'b1);
      play_phase(16'd1, 1'b1, 24, 1'b0);
      play_phase(16'd65535, 1'b0, 12, 1'b0);

      // overfill the table at time zero so one tick emits every entry once
      write_reg(CSR_TICK_DIVIDE, 16'd1);
      write_reg(CSR_ONE_SHOT, {15'd0, 1'($urandom_range(0, 1))});
      send(OP_CLEAR, 0, 0, 0, 0, 0, 1'b1);
      repeat (DEPTH + 2)
         send(OP_APPEND, 0, 8'($urandom), 8'($urandom), 8'($urandom),
              3'($urandom_range(0, MAX_LENGTH)), 1'b1);
      repeat (3) send(OP_TICK, 0, 0, 0, 0, 0, 1'b1);

      play_phase(16'd3, 1'b0, 16, 1'b0);
      play_phase(16'($urandom_range(1, 4)), 1'($urandom_range(0, 1)), 16, 1'b0);

      start <= 1'b0;
      while (due_messages.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("clip_event_playback_sequencer verification clean");
      end else begin
         $display("clip_event_playback_sequencer verification failed");
      end
      $finish;
   end

endmodule
